[sv/bbc_pkg.sv]
// Shared types, character codes and decode helpers for the bracket balance checker.
package bbc_pkg;

    typedef enum logic [2:0] {
        EV_OTHER    = 3'd0,
        EV_OPEN     = 3'd1,
        EV_MATCH    = 3'd2,
        EV_MISMATCH = 3'd3,
        EV_EMPTY    = 3'd4,
        EV_OVERFLOW = 3'd5
    } t_event;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_BRACE  = 2'd0;
    localparam t_kind KIND_PAREN  = 2'd1;
    localparam t_kind KIND_SQUARE = 2'd2;

    localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B;
    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

    typedef struct packed {
        logic  is_open;
        logic  is_close;
        t_kind kind;
    } t_decode;

    function automatic t_decode f_decode(input logic [7:0] ch);
        t_decode d;
        d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_BRACE};
        case (ch)
            CH_OPEN_BRACE:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_BRACE};
            CH_OPEN_PAREN:   d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_PAREN};
            CH_OPEN_SQUARE:  d = '{is_open: 1'b1, is_close: 1'b0, kind: KIND_SQUARE};
            CH_CLOSE_BRACE:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_BRACE};
            CH_CLOSE_PAREN:  d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_PAREN};
            CH_CLOSE_SQUARE: d = '{is_open: 1'b0, is_close: 1'b1, kind: KIND_SQUARE};
            default:         d = '{is_open: 1'b0, is_close: 1'b0, kind: KIND_BRACE};
        endcase
        return d;
    endfunction

endpackage

[sv/bbc_if.sv]
// Valid/ready channel interfaces for the character input and the result output.
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface bbc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [1:0]  expected_kind;
    logic [15:0] position;
    logic [6:0]  depth;
    logic        done_res;
    logic        correct;

    modport source (output valid, output event_res, output expected_kind, output position,
                    output depth, output done_res, output correct, input ready);
    modport sink   (input valid, input event_res, input expected_kind, input position,
                    input depth, input done_res, input correct, output ready);
endinterface

[sv/bbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bracket_balance_checker.sv]
// Bracket balance checker top level: stack RAM, top-of-stack register and result register.
//
// Takes one character beat per cycle, with a last-of-string flag, and returns exactly one
// result beat per character. Throughput is one character per clock unless results stall:
// the top of the bracket stack sits in a register and the entry beneath it is prefetched
// from the stack RAM (read address = level after this beat minus two), so a push, a pop
// or a compare never waits on the RAM. After a push the entry beneath the new top is the
// old top, which is forwarded from a register instead of the RAM. The result beat is
// registered and appears in the cycle after its input beat is taken; the result register
// frees itself when the downstream side takes the beat, so input is taken in the same
// cycle as output is drained. Errors (mismatch, close on an empty stack, open on a full
// stack) are sticky until the last character, whose result carries correct = 1 only for
// an empty stack and a clean string; state then clears for the next string. Stack RAM
// contents need no initialization, so there is no clearing pass after reset.
module bracket_balance_checker
    import bbc_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bbc_in_if.sink         i_in,
    bbc_out_if.source      o_out
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Control state
    logic [LW-1:0] r_level, n_level;
    logic [15:0]   r_index, n_index;
    logic          r_err,   n_err;
    logic          r_fwd_sel, n_fwd_sel;
    logic          r_out_valid, n_out_valid;

    // Payload state
    t_kind         r_top,  n_top;
    t_kind         r_fwd,  n_fwd;
    t_event        r_event, n_event;
    t_kind         r_expected, n_expected;
    logic [15:0]   r_position, n_position;
    logic [6:0]    r_depth, n_depth;
    logic          r_done, n_done;
    logic          r_correct, n_correct;

    logic          w_accept;
    t_decode       w_dec;
    t_kind         w_below;
    t_kind         w_rdata;
    logic [LW-1:0] w_level_stk;
    logic          w_push, w_pop, w_err_now;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_level32;

    // Accept a new beat whenever the result register is empty or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_dec      = f_decode(i_in.char_code);

    // Entry beneath the top: forwarded value unless the last beat was a pop
    assign w_below = r_fwd_sel ? r_fwd : w_rdata;

    always_comb begin
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_err_now   = 1'b0;
        n_event     = EV_OTHER;
        n_expected  = KIND_BRACE;
        w_level_stk = r_level;
        if (w_dec.is_open) begin
            if (r_level >= LW'(STACK_DEPTH)) begin
                n_event   = EV_OVERFLOW;
                w_err_now = 1'b1;
            end else begin
                n_event     = EV_OPEN;
                w_push      = 1'b1;
                w_level_stk = r_level + 1'b1;
            end
        end else if (w_dec.is_close) begin
            if (r_level == '0) begin
                n_event   = EV_EMPTY;
                w_err_now = 1'b1;
            end else if (r_top == w_dec.kind) begin
                n_event     = EV_MATCH;
                w_pop       = 1'b1;
                w_level_stk = r_level - 1'b1;
            end else begin
                n_event    = EV_MISMATCH;
                n_expected = r_top;
                w_err_now  = 1'b1;
            end
        end
    end

    // Spill the old top into the RAM on a push; prefetch the new below-top entry
    assign w_we    = w_accept && w_push && (r_level != '0);
    assign w_waddr = AW'(r_level - 1'b1);
    assign w_raddr = AW'(w_level_stk - LW'(2));

    bbc_ram #(
        .WIDTH ($bits(t_kind)),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_top),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_level32 = 32'(w_level_stk);

    always_comb begin
        n_level     = r_level;
        n_index     = r_index;
        n_err       = r_err;
        n_top       = r_top;
        n_fwd       = w_below;
        n_fwd_sel   = 1'b1;
        n_out_valid = r_out_valid && !o_out.ready;
        n_position  = r_position;
        n_depth     = r_depth;
        n_done      = r_done;
        n_correct   = r_correct;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_position  = r_index;
            n_depth     = (w_level32 > 32'd127) ? 7'd127 : w_level32[6:0];
            n_done      = i_in.last_char;
            n_correct   = i_in.last_char && (w_level_stk == '0) && !(r_err || w_err_now);
            if (w_push) begin
                n_top = w_dec.kind;
                n_fwd = r_top;
            end else if (w_pop) begin
                n_top     = w_below;
                n_fwd_sel = 1'b0;
            end
            // Clear at end of string, else advance
            if (i_in.last_char) begin
                n_level = '0;
                n_index = '0;
                n_err   = 1'b0;
            end else begin
                n_level = w_level_stk;
                n_index = (r_index == 16'hFFFF) ? r_index : r_index + 16'd1;
                n_err   = r_err || w_err_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_index     <= '0;
            r_err       <= 1'b0;
            r_fwd_sel   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_level     <= n_level;
            r_index     <= n_index;
            r_err       <= n_err;
            r_fwd_sel   <= n_fwd_sel;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers; the result fields load only on an accepted beat
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_fwd <= n_fwd;
        if (w_accept) begin
            r_event    <= n_event;
            r_expected <= n_expected;
        end
        r_position <= n_position;
        r_depth    <= n_depth;
        r_done     <= n_done;
        r_correct  <= n_correct;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_res     = r_event;
    assign o_out.expected_kind = r_expected;
    assign o_out.position      = r_position;
    assign o_out.depth         = r_depth;
    assign o_out.done_res      = r_done;
    assign o_out.correct       = r_correct;

endmodule

[sv/bbc_checker.sv]
// Port-level assertions for the bracket balance checker and the bind that attaches them.
module bbc_checker
    import bbc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_event_res,
    input logic [1:0]  i_expected_kind,
    input logic [15:0] i_position,
    input logic [6:0]  i_depth,
    input logic        i_done_res,
    input logic        i_correct
);

    // A result beat rises only in the cycle after an input beat was taken
    a_out_follows_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result beat without a preceding input beat");

    // Correct is only reported on the last character of a string
    a_correct_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_correct) |-> i_done_res)
        else $error("correct set on a result that is not end of string");

    // A correct string ends with an empty stack and no error on its last beat
    a_correct_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_correct) |->
            (i_depth == 7'd0 && i_event_res != EV_MISMATCH && i_event_res != EV_EMPTY
             && i_event_res != EV_OVERFLOW))
        else $error("correct reported with open brackets or an error on the last beat");

    // Expected closer is zero except on a mismatch
    a_expected_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_event_res != EV_MISMATCH) |-> (i_expected_kind == KIND_BRACE))
        else $error("expected closer set on a non-mismatch beat");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_event_res) && $stable(i_position)
             && $stable(i_depth) && $stable(i_correct)))
        else $error("stalled result beat changed");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_event_res     (o_out.event_res),
    .i_expected_kind (o_out.expected_kind),
    .i_position      (o_out.position),
    .i_depth         (o_out.depth),
    .i_done_res      (o_out.done_res),
    .i_correct       (o_out.correct)
);
